### hw/rtl/mws_pkg.sv
// Shared constants, codes and the quarter-wave sine table builder.
package mws_pkg;

    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned QTR_N           = 1 << SINE_TABLE_BITS;
    localparam int unsigned SINE_ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int unsigned SINE_W          = 16;

    localparam int unsigned FREQ_W  = 23;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned AMP_W   = 15;
    localparam int unsigned WAVE_W  = 3;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned PROD_W  = PHASE_W + AMP_W;

    // floor(pi/2 * 2^31)
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

    typedef enum logic [WAVE_W-1:0] {
        SHAPE_SINE     = 3'd0,
        SHAPE_SQUARE   = 3'd1,
        SHAPE_TRIANGLE = 3'd2,
        SHAPE_SAW      = 3'd3
    } t_wave;

    typedef logic [SINE_W-1:0] t_sine_rom [0:QTR_N];

    // Unsigned shift-subtract quotient; only used while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi/2 * i / N) in Q15: Taylor series in Q31, rounded and clamped.
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] div;
        longint      sum;
        longint      r;
        x    = (HALF_PI_Q31 * 64'(i)) >> SINE_TABLE_BITS;
        term = x;
        sum  = longint'(x);
        for (int unsigned k = 1; k <= 12; k++) begin
            term = (term * x) >> 31;
            term = (term * x) >> 31;
            div  = 64'((2 * k) * (2 * k + 1));
            term = udiv64(term, div);
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd32768) >>> 16;
        if (r > 64'sd32768) begin
            r = 64'sd32768;
        end
        return SINE_W'(r);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom t;
        for (int unsigned i = 0; i <= QTR_N; i++) begin
            t[i] = sine_q15(i);
        end
        return t;
    endfunction

endpackage

### hw/rtl/mws_sine_rom.sv
// Quarter-wave sine ROM, one read port, registered data.
module mws_sine_rom import mws_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SINE_ADDR_W-1:0] i_addr,
    output logic [SINE_W-1:0]      o_data
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [SINE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### hw/rtl/multi_waveform_sample_top.sv
// Top level of the multi-waveform sample generator.
//
// Input channel (i_valid / o_ready): one beat carries frequency (Hz, Q.8),
// time point (s, Q.24), amplitude (0..32767) and a waveform code
// (sine, square, triangle, saw; other codes give zero).
// Output channel (o_valid / i_ready): one beat per input beat, a signed
// 16-bit sample, in input order.
//
// Pipeline, four register stages:
//   S1  phase = low 32 bits of frequency * time (23x32 multiplier)
//   S2  sine ROM read (1025 x 16, registered) and linear magnitude / sign
//   S3  magnitude * amplitude (32x15 multiplier)
//   S4  scale by 2^-31, apply sign -> output register
// Throughput: one beat per cycle while i_ready is high, set by the two
// multipliers and the single ROM port each being used once per beat.
// Each stage loads when it is empty or the stage after it moves, so a
// stalled receiver fills bubbles first and then holds; nothing is lost
// or repeated. o_ready follows i_ready combinationally through that chain.
// Reset (synchronous, active low) empties every stage; there is no
// state kept between beats and the ROM needs no initialization pass.
module multi_waveform_sample_top import mws_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [FREQ_W-1:0]          i_frequency,
    input  logic [TIME_W-1:0]          i_time_point,
    input  logic [AMP_W-1:0]           i_amplitude,
    input  logic [WAVE_W-1:0]          i_waveform,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam logic [PHASE_W-1:0] FULL_SCALE = {1'b1, {(PHASE_W-1){1'b0}}};
    localparam logic [PHASE_W:0]   PHASE_WRAP = {1'b1, {PHASE_W{1'b0}}};

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage 1
    logic [FREQ_W+TIME_W-1:0] n1_prod;
    logic [PHASE_W-1:0]       r1_phase;
    logic [AMP_W-1:0]         r1_amp;
    logic [WAVE_W-1:0]        r1_wave;

    // stage 2
    logic [1:0]               quad;
    logic [SINE_TABLE_BITS-1:0] k_idx;
    logic [SINE_ADDR_W-1:0]   rom_addr;
    logic                     low_half;
    logic [PHASE_W-1:0]       lin_mag;
    logic [PHASE_W-1:0]       n2_lin;
    logic                     n2_neg;
    logic                     n2_use_rom;
    logic [PHASE_W-1:0]       r2_lin;
    logic                     r2_neg;
    logic                     r2_use_rom;
    logic [AMP_W-1:0]         r2_amp;
    logic [SINE_W-1:0]        rom_data;

    // stage 3
    logic [PHASE_W-1:0]       op_mag;
    logic [PROD_W-1:0]        r3_prod;
    logic                     r3_neg;

    // stage 4
    logic [SAMPLE_W-1:0]      mag4;
    logic [SAMPLE_W-1:0]      r4_sample;

    // per-stage load enables, back from the output
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // S1: phase is the fractional part of the Q.32 product
    assign n1_prod = (FREQ_W+TIME_W)'(i_frequency) * (FREQ_W+TIME_W)'(i_time_point);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_phase <= n1_prod[PHASE_W-1:0];
            r1_amp   <= i_amplitude;
            r1_wave  <= i_waveform;
        end
    end

    // S2: quadrant folding for the ROM, linear magnitude for the rest
    assign quad     = r1_phase[PHASE_W-1 -: 2];
    assign k_idx    = r1_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    assign rom_addr = quad[0] ? SINE_ADDR_W'(QTR_N) - {1'b0, k_idx} : {1'b0, k_idx};
    assign low_half = !r1_phase[PHASE_W-1];
    // 2^32 - p is at most 2^31 in the upper half
    assign lin_mag  = low_half ? r1_phase : PHASE_W'(PHASE_WRAP - {1'b0, r1_phase});

    always_comb begin
        n2_lin     = '0;
        n2_neg     = 1'b0;
        n2_use_rom = 1'b0;
        unique case (r1_wave)
            SHAPE_SINE: begin
                n2_use_rom = 1'b1;
                n2_neg     = quad[1];
            end
            SHAPE_SQUARE: begin
                // full scale times amplitude, shifted by 31, gives amplitude
                n2_lin = FULL_SCALE;
                n2_neg = low_half && (r1_phase != '0);
            end
            SHAPE_TRIANGLE: begin
                n2_lin = lin_mag;
            end
            SHAPE_SAW: begin
                n2_lin = lin_mag;
                n2_neg = !low_half;
            end
            default: begin
                n2_lin = '0;
            end
        endcase
    end

    mws_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_lin     <= n2_lin;
            r2_neg     <= n2_neg;
            r2_use_rom <= n2_use_rom;
            r2_amp     <= r1_amp;
        end
    end

    // S3: Q15 table value lifted to Q31 so every waveform shares one scaler
    assign op_mag = r2_use_rom ? {rom_data, {(PHASE_W-SINE_W){1'b0}}} : r2_lin;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_prod <= PROD_W'(op_mag) * PROD_W'(r2_amp);
            r3_neg  <= r2_neg;
        end
    end

    // S4: truncate magnitude, then apply sign (truncation toward zero)
    assign mag4 = r3_prod[PROD_W-1 -: SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_sample <= r3_neg ? SAMPLE_W'(-mag4) : mag4;
        end
    end

    assign o_valid  = r_v4;
    assign o_sample = r4_sample;

    // magnitude is bounded by the 15-bit amplitude
    a_no_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample != {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("sample reached the most negative code");

    // folded sine address stays inside the table
    a_rom_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (rom_addr <= SINE_ADDR_W'(QTR_N)))
        else $error("sine ROM address past the quarter wave");

    // table values never exceed one in Q15
    a_rom_data_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r2_use_rom) |-> (rom_data <= SINE_W'(32768)))
        else $error("sine ROM value above full scale");

    // unknown waveform codes produce a zero operand
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && en2 && r1_wave[2]) |=> (r2_lin == '0 && !r2_use_rom))
        else $error("unknown waveform code not forced to zero");

    // a stalled stage 3 keeps its product
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en3) |=> (r_v3 && $stable(r3_prod) && $stable(r3_neg)))
        else $error("stage 3 changed while stalled");

endmodule

### dv/multi_waveform_sample_top_tb.sv
// Testbench for multi_waveform_sample_top: directed table plus random beats.
`timescale 1ns / 100ps

module multi_waveform_sample_top_tb import mws_pkg::*; ();

    // Codes outside the enum: the block must answer them with a zero sample.
    localparam logic [WAVE_W-1:0] WAVE_NONE     = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_CODE_TOP = 3'd7;

    localparam logic [FREQ_W-1:0] FREQ_AUDIO_MAX = 23'd6144000;  // 24 kHz, Q.8
    localparam logic [FREQ_W-1:0] FREQ_ALL_ONES  = '1;
    localparam logic [AMP_W-1:0]  AMP_MAX        = '1;

    localparam int PIPE_DEPTH    = 4;     // input beat to o_valid
    localparam int RANDOM_BEATS  = 1530;
    localparam int PRESSURE_AT   = 300;   // result count at which the long hold starts
    localparam int PRESSURE_HOLD = 120;   // cycles of i_ready low during that hold
    localparam int QUIET_LIMIT   = 1000;  // cycles without any handshake

    typedef struct {
        logic [FREQ_W-1:0]          freq;
        logic [TIME_W-1:0]          tim;
        logic [AMP_W-1:0]           amp;
        logic [WAVE_W-1:0]          wave;
        bit                         known;  // want is typed in, not predicted
        logic signed [SAMPLE_W-1:0] want;
    } t_tone_beat;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic [FREQ_W-1:0]          i_frequency  = '0;
    logic [TIME_W-1:0]          i_time_point = '0;
    logic [AMP_W-1:0]           i_amplitude  = '0;
    logic [WAVE_W-1:0]          i_waveform   = '0;
    logic                       i_ready      = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample;

    // Quarter-wave sine in Q15, same table the block holds in ROM.
    int unsigned                sine_quarter [0:QTR_N];
    // Samples still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_tone_beat                 directed_rows [$];

    int error_count   = 0;
    int samples_seen  = 0;
    int quiet_cycles  = 0;
    int send_calm     = 0;  // beats left in a no-gap burst, sender side
    int recv_calm     = 0;  // same, receiver side

    multi_waveform_sample_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frequency  (i_frequency),
        .i_time_point (i_time_point),
        .i_amplitude  (i_amplitude),
        .i_waveform   (i_waveform),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample     (o_sample)
    );

    always #1 i_clk = ~i_clk;

    // sin(pi/2 * idx / N): Taylor series in Q31 with truncated terms,
    // then rounded to Q15 and clamped at 1.0.
    function automatic int unsigned quarter_sine_q15(input int unsigned idx);
        logic [63:0] angle;
        logic [63:0] series_term;
        longint      acc;
        longint      rounded;
        angle       = (HALF_PI_Q31 * 64'(idx)) >> SINE_TABLE_BITS;
        series_term = angle;
        acc         = longint'(angle);
        for (int unsigned n = 1; n <= 12; n++) begin
            series_term = (series_term * angle) >> 31;
            series_term = (series_term * angle) >> 31;
            series_term = series_term / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                acc = acc - longint'(series_term);
            end else begin
                acc = acc + longint'(series_term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (acc + 64'sd32768) >>> 16;
        if (rounded > 64'sd32768) begin
            rounded = 64'sd32768;
        end
        return int'(rounded);
    endfunction

    // Sample for one beat: phase is the low 32 bits of frequency * time.
    function automatic logic signed [SAMPLE_W-1:0] oscillator_sample(
        input logic [FREQ_W-1:0] freq,
        input logic [TIME_W-1:0] tim,
        input logic [AMP_W-1:0]  amp,
        input logic [WAVE_W-1:0] wave
    );
        logic [54:0]                full;
        logic [PHASE_W-1:0]         phase;
        logic [PHASE_W:0]           ramp;
        logic [1:0]                 quad;
        logic [SINE_TABLE_BITS-1:0] k;
        int unsigned                idx;
        logic [47:0]                scaled;
        int                         level;
        full  = 55'(freq) * 55'(tim);
        phase = full[PHASE_W-1:0];
        // Distance from the nearer end of the period, for the linear shapes.
        ramp  = phase[31] ? (33'h1_0000_0000 - 33'(phase)) : 33'(phase);
        level = 0;
        case (wave)
            SHAPE_SINE: begin
                quad   = phase[31:30];
                k      = phase[30-SINE_TABLE_BITS +: SINE_TABLE_BITS];
                idx    = quad[0] ? (QTR_N - int'(k)) : int'(k);
                scaled = (48'(sine_quarter[idx]) * 48'(amp)) >> 15;
                level  = quad[1] ? -int'(scaled) : int'(scaled);
            end
            SHAPE_SQUARE: begin
                level = (phase != '0 && !phase[31]) ? -int'(amp) : int'(amp);
            end
            SHAPE_TRIANGLE: begin
                scaled = (48'(ramp) * 48'(amp)) >> 31;
                level  = int'(scaled);
            end
            SHAPE_SAW: begin
                scaled = (48'(ramp) * 48'(amp)) >> 31;
                level  = phase[31] ? -int'(scaled) : int'(scaled);
            end
            default: level = 0;
        endcase
        return SAMPLE_W'(level);
    endfunction

    // Idle cycles before the next beat, drawn at random, with occasional
    // bursts of back-to-back beats so that long stretches run with no gaps at all.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic add_row(
        input logic [FREQ_W-1:0]          freq,
        input logic [TIME_W-1:0]          tim,
        input logic [AMP_W-1:0]           amp,
        input logic [WAVE_W-1:0]          wave,
        input bit                         known,
        input logic signed [SAMPLE_W-1:0] want
    );
        t_tone_beat row;
        row.freq  = freq;
        row.tim   = tim;
        row.amp   = amp;
        row.wave  = wave;
        row.known = known;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken. The expectation is queued at the accepting rising edge.
    task automatic send_beat(input t_tone_beat b);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_frequency  <= b.freq;
        i_time_point <= b.tim;
        i_amplitude  <= b.amp;
        i_waveform   <= b.wave;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_samples.push_back(b.known ? b.want
                                  : oscillator_sample(b.freq, b.tim, b.amp, b.wave));
        @(negedge i_clk);
    endtask

    // Stall detector: any cycle with a handshake on either side clears it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls per beat, one long hold partway through so
    // the pipeline fills and o_ready drops while the sender keeps offering.
    initial begin
        int                         stall;
        logic signed [SAMPLE_W-1:0] want;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (samples_seen == PRESSURE_AT) begin
                stall = PRESSURE_HOLD;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            samples_seen++;
            if (pending_samples.size() == 0) begin
                $error("sample beat %0d with nothing outstanding: got %0d",
                       samples_seen, o_sample);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want) begin
                    $error("sample mismatch at beat %0d: expected %0d, actual %0d",
                           samples_seen, want, o_sample);
                    error_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // Main sequence: table build, reset, directed table, random beats, drain.
    initial begin
        t_tone_beat b;
        for (int unsigned i = 0; i <= QTR_N; i++) begin
            sine_quarter[i] = quarter_sine_q15(i);
        end

        // Phase zero: every shape at its start point.
        add_row('0, '0, AMP_MAX, SHAPE_SINE,     1, 16'sd0);
        add_row('0, '0, AMP_MAX, SHAPE_SQUARE,   1, 16'sd32767);
        add_row('0, '0, AMP_MAX, SHAPE_TRIANGLE, 1, 16'sd0);
        add_row('0, '0, AMP_MAX, SHAPE_SAW,      1, 16'sd0);
        // Smallest nonzero phase: square already in its low half.
        add_row(23'd1, 32'd1, AMP_MAX, SHAPE_SQUARE,   1, -16'sd32767);
        add_row(23'd1, 32'd1, AMP_MAX, SHAPE_TRIANGLE, 1, 16'sd0);
        // Half period: square flips high, triangle peaks, saw wraps negative.
        add_row(23'd1, 32'h8000_0000, AMP_MAX, SHAPE_SQUARE,   1, 16'sd32767);
        add_row(23'd1, 32'h8000_0000, AMP_MAX, SHAPE_TRIANGLE, 1, 16'sd32767);
        add_row(23'd1, 32'h8000_0000, AMP_MAX, SHAPE_SAW,      1, -16'sd32767);
        add_row(23'd1, 32'h8000_0000, AMP_MAX, SHAPE_SINE,     1, 16'sd0);
        // Sine at the quadrant edges and in between.
        add_row(23'd1, 32'h4000_0000, AMP_MAX, SHAPE_SINE, 0, '0);
        add_row(23'd1, 32'hC000_0000, AMP_MAX, SHAPE_SINE, 0, '0);
        add_row(23'd1, 32'h2000_0000, 15'd20000, SHAPE_SINE, 0, '0);
        // Last phase step before wrap.
        add_row(23'd1, 32'hFFFF_FFFF, AMP_MAX, SHAPE_SQUARE, 1, 16'sd32767);
        add_row(23'd1, 32'hFFFF_FFFF, AMP_MAX, SHAPE_SAW,    1, 16'sd0);
        // All-ones fields, past the audio range.
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, SHAPE_SINE,     0, '0);
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, SHAPE_SQUARE,   0, '0);
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, SHAPE_TRIANGLE, 0, '0);
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, SHAPE_SAW,      0, '0);
        add_row(FREQ_AUDIO_MAX, 32'h0123_4567, 15'd12345, SHAPE_SINE, 0, '0);
        // Unknown codes give silence.
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, WAVE_NONE,     1, 16'sd0);
        add_row(FREQ_ALL_ONES, 32'hFFFF_FFFF, AMP_MAX, WAVE_CODE_TOP, 1, 16'sd0);
        // Zero amplitude, and alternating bit patterns.
        add_row(23'd1, 32'h6000_0000, '0, SHAPE_SAW, 1, 16'sd0);
        add_row(23'h2A_AAAA, 32'h5555_5555, 15'h2AAA, SHAPE_TRIANGLE, 0, '0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i]);
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            case ($urandom_range(0, 9))
                0:       b.freq = '0;
                1:       b.freq = FREQ_ALL_ONES;
                2, 3, 4: b.freq = FREQ_W'($urandom_range(0, 32'(FREQ_AUDIO_MAX)));
                default: b.freq = FREQ_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       b.tim = TIME_W'($urandom_range(0, 255));
                1:       b.tim = '1;
                default: b.tim = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       b.amp = '0;
                1:       b.amp = AMP_MAX;
                default: b.amp = AMP_W'($urandom_range(0, 32767));
            endcase
            // Mostly real shapes; a few unknown codes mixed in.
            if ($urandom_range(0, 9) == 0) begin
                b.wave = WAVE_W'($urandom_range(32'(WAVE_NONE), 32'(WAVE_CODE_TOP)));
            end else begin
                b.wave = WAVE_W'($urandom_range(32'(SHAPE_SINE), 32'(SHAPE_SAW)));
            end
            b.known = 1'b0;
            b.want  = '0;
            send_beat(b);
        end
        i_valid <= 1'b0;

        while (pending_samples.size() != 0) @(posedge i_clk);
        // Stray beats after the last expected one still get flagged.
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
